/* rtl/cdll_pkg.sv */
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and constants of the circular doubly linked list block.
// ----------------------------------------------------------------------------
package cdll_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int TYPE_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 5;

    localparam logic [TYPE_W-1:0] REQ_INS_FIRST  = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INS_LAST   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_INS_AFTER  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_INS_BEFORE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DELETE     = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_SEARCH     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_TAIL,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_SINGLE,
        S_UNLINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                ready;
        logic                rd_next;
        logic                take_tail;
        logic                take_hit;
        logic                step;
        logic                wr_link1;
        logic                wr_link2;
        logic                wr_single;
        logic                wr_unlink;
        logic                clr_list;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                set_pos;
        logic                load_out;
    } cmd_t;

    typedef struct packed {
        logic              req_valid;
        logic [TYPE_W-1:0] req_type;
        logic              count_zero;
        logic              count_one;
        logic              pool_full;
        logic              key_match;
        logic              last_node;
        logic              out_stall;
    } stat_t;

endpackage

/* rtl/cdll_req_if.sv */
// ----------------------------------------------------------------------------
// cdll_req_if
// Request channel: valid/ready handshake carrying one list request per beat.
// ----------------------------------------------------------------------------
interface cdll_req_if;
    import cdll_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] match_key;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, output req_type, output match_key, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input match_key, input new_value,
                    output ready);
endinterface

/* rtl/cdll_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdll_rsp_if
// Response channel: valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface cdll_rsp_if;
    import cdll_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;

    modport source (output valid, output status, output found_position, input ready);
    modport sink   (input valid, input status, input found_position, output ready);
endinterface

/* rtl/cdll_ram.sv */
// ----------------------------------------------------------------------------
// cdll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/cdll_ctrl.sv */
// ----------------------------------------------------------------------------
// cdll_ctrl
// Controller state machine: sequences the walk and the link updates.
// ----------------------------------------------------------------------------
module cdll_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  cdll_pkg::stat_t stat,
    output cdll_pkg::cmd_t  cmd
);
    import cdll_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                case (stat.req_type)
                    REQ_INS_FIRST, REQ_INS_LAST:
                    begin
                        if (stat.pool_full)
                        begin
                            state_next = S_DONE;
                        end
                        else if (stat.count_zero)
                        begin
                            state_next = S_SINGLE;
                        end
                        else
                        begin
                            state_next = S_TAIL;
                        end
                    end
                    REQ_INS_AFTER, REQ_INS_BEFORE, REQ_DELETE, REQ_SEARCH:
                    begin
                        state_next = stat.count_zero ? S_DONE : S_WALK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TAIL:
            begin
                state_next = S_LINK1;
            end
            S_WALK:
            begin
                if (stat.key_match)
                begin
                    case (stat.req_type)
                        REQ_INS_AFTER, REQ_INS_BEFORE:
                        begin
                            state_next = stat.pool_full ? S_DONE : S_LINK1;
                        end
                        REQ_DELETE:
                        begin
                            state_next = stat.count_one ? S_DONE : S_UNLINK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (stat.last_node)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK1:
            begin
                state_next = S_LINK2;
            end
            S_LINK2, S_SINGLE, S_UNLINK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            S_FETCH:
            begin
                case (stat.req_type)
                    REQ_INS_FIRST, REQ_INS_LAST:
                    begin
                        if (stat.pool_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                    end
                    REQ_INS_AFTER, REQ_INS_BEFORE, REQ_DELETE, REQ_SEARCH:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_TAIL:
            begin
                cmd.take_tail = 1'b1;
            end
            S_WALK:
            begin
                if (stat.key_match)
                begin
                    cmd.take_hit = 1'b1;
                    case (stat.req_type)
                        REQ_INS_AFTER, REQ_INS_BEFORE:
                        begin
                            if (stat.pool_full)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_FULL;
                            end
                        end
                        REQ_DELETE:
                        begin
                            cmd.clr_list = stat.count_one;
                        end
                        default:
                        begin
                            cmd.set_pos = 1'b1;
                        end
                    endcase
                end
                else if (stat.last_node)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.step    = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            S_LINK1:
            begin
                cmd.wr_link1 = 1'b1;
            end
            S_LINK2:
            begin
                cmd.wr_link2 = 1'b1;
            end
            S_SINGLE:
            begin
                cmd.wr_single = 1'b1;
            end
            S_UNLINK:
            begin
                cmd.wr_unlink = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = !stat.out_stall;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end
endmodule

/* rtl/cdll_dpath.sv */
// ----------------------------------------------------------------------------
// cdll_dpath
// Datapath: node RAMs, head and count, free map, walk registers and the
// output register.
// ----------------------------------------------------------------------------
module cdll_dpath #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    cdll_req_if.sink        req,
    cdll_rsp_if.source      rsp,
    input  cdll_pkg::cmd_t  cmd,
    output cdll_pkg::stat_t stat
);
    import cdll_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [TYPE_W-1:0]   type_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [IW-1:0]       cur_reg;
    logic [CW-1:0]       k_reg;
    logic [IW-1:0]       hit_reg;
    logic [IW-1:0]       a_reg;
    logic [IW-1:0]       b_reg;
    logic                new_head_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [IW-1:0]       head_reg;
    logic [IW-1:0]       head_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CAPACITY-1:0] free_reg;
    logic [CAPACITY-1:0] free_next;
    logic [IW-1:0]       slot_reg;
    logic                full_reg;
    logic [IW-1:0]       slot_pick;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic [DATA_W-1:0]   value_rd;
    logic [IW-1:0]       next_rd;
    logic [IW-1:0]       prev_rd;
    logic [IW-1:0]       rd_addr;

    logic                val_we;
    logic                next_we;
    logic [IW-1:0]       next_waddr;
    logic [IW-1:0]       next_wdata;
    logic                prev_we;
    logic [IW-1:0]       prev_waddr;
    logic [IW-1:0]       prev_wdata;

    logic                accept;
    logic [CW-1:0]       k_plus;

    assign accept = req.valid && cmd.ready;
    assign k_plus = k_reg + CW'(1);
    assign rd_addr = cmd.rd_next ? next_rd : head_reg;

    cdll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (slot_reg),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (value_rd)
    );

    cdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    cdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rd)
    );

    always_comb
    begin
        val_we     = cmd.wr_link1 || cmd.wr_single;
        next_we    = cmd.wr_link1 || cmd.wr_link2 || cmd.wr_single || cmd.wr_unlink;
        prev_we    = next_we;
        next_waddr = slot_reg;
        next_wdata = slot_reg;
        prev_waddr = slot_reg;
        prev_wdata = slot_reg;
        if (cmd.wr_link1)
        begin
            next_wdata = b_reg;
            prev_wdata = a_reg;
        end
        else if (cmd.wr_link2)
        begin
            next_waddr = a_reg;
            prev_waddr = b_reg;
        end
        else if (cmd.wr_unlink)
        begin
            next_waddr = a_reg;
            next_wdata = b_reg;
            prev_waddr = b_reg;
            prev_wdata = a_reg;
        end
    end

    always_comb
    begin
        slot_pick = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                slot_pick = IW'(i);
            end
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        free_next  = free_reg;
        if (cmd.wr_single)
        begin
            head_next           = slot_reg;
            count_next          = CW'(1);
            free_next[slot_reg] = 1'b0;
        end
        else if (cmd.wr_link2)
        begin
            head_next           = new_head_reg ? slot_reg : head_reg;
            count_next          = count_reg + CW'(1);
            free_next[slot_reg] = 1'b0;
        end
        else if (cmd.wr_unlink)
        begin
            head_next          = new_head_reg ? b_reg : head_reg;
            count_next         = count_reg - CW'(1);
            free_next[hit_reg] = 1'b1;
        end
        else if (cmd.clr_list)
        begin
            head_next          = '0;
            count_next         = '0;
            free_next[cur_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            slot_reg  <= slot_pick;
            full_reg  <= ~|free_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req.req_type;
            key_reg    <= req.match_key;
            val_reg    <= req.new_value;
            cur_reg    <= head_reg;
            k_reg      <= '0;
            status_reg <= ST_OK;
            pos_reg    <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                cur_reg <= next_rd;
                k_reg   <= k_plus;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.set_pos)
            begin
                pos_reg <= POS_W'(k_plus);
            end
        end

        if (cmd.take_tail)
        begin
            a_reg        <= prev_rd;
            b_reg        <= head_reg;
            new_head_reg <= (type_reg == REQ_INS_FIRST);
        end
        else if (cmd.take_hit)
        begin
            hit_reg      <= cur_reg;
            new_head_reg <= (type_reg != REQ_INS_AFTER) && (cur_reg == head_reg);
            a_reg        <= (type_reg == REQ_INS_AFTER) ? cur_reg : prev_rd;
            b_reg        <= (type_reg == REQ_INS_BEFORE) ? cur_reg : next_rd;
        end

        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_pos_reg    <= pos_reg;
        end
    end

    assign req.ready          = cmd.ready;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_position = out_pos_reg;

    always_comb
    begin
        stat            = '0;
        stat.req_valid  = req.valid;
        stat.req_type   = type_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_one  = (count_reg == CW'(1));
        stat.pool_full  = full_reg;
        stat.key_match  = (value_rd == key_reg);
        stat.last_node  = (k_plus == count_reg);
        stat.out_stall  = out_valid_reg && !rsp.ready;
    end
endmodule

/* rtl/circular_doubly_linked_list.sv */
// ----------------------------------------------------------------------------
// circular_doubly_linked_list
// Circular doubly linked list of signed 32-bit values in a pool of CAPACITY
// nodes, driven by insert, delete and search requests.
//
// One request beat on req gives exactly one result beat on rsp (status and
// the 1-based search position). Requests are handled one at a time; req.ready
// is high only while the block is idle, but a finished result waiting in the
// output register does not hold back the next request.
// A key request on an empty list, a pool-full insert at head or tail, or an
// unused request type goes straight to its result. An insert into an empty
// list writes a single node; an insert at head or tail reads the tail and
// then writes the two links. A key request walks the list node by node, then
// a link insert writes the two links and a delete that leaves nodes behind
// unlinks the hit node. A link insert needs a free slot. The walk is set by
// the node RAMs: one node's read per cycle. The next request can be taken
// in the cycle after the result is loaded. Reset empties the list and frees
// every slot at once; node storage is not cleared. While rsp is stalled the
// result is held and the block finishes its current request, then waits
// before it returns to idle.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list #(
    parameter int CAPACITY = cdll_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cdll_req_if.sink   req,
    cdll_rsp_if.source rsp
);
    import cdll_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cdll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    cdll_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in progress");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp.valid)
        else $error("loaded result not presented");

    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_link1, cmd.wr_link2, cmd.wr_single, cmd.wr_unlink, cmd.clr_list}))
        else $error("more than one list update in a cycle");

    a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_link2 |-> $past(cmd.wr_link1))
        else $error("second link write without the first");

    a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !cmd.load_out)
        else $error("result overwritten while stalled");
endmodule
